// ===== rtl/bfp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfp_pkg - shared types and constants for the bit FIFO packer
// Operation and status codes, the result record and the sequencer states.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int VAL_W           = 32;   // value / read_value field width
  localparam int CNT_W           = 6;    // count / bits_done field width
  localparam int BYTE_W          = 8;
  localparam int STORE_BYTES_DEF = 512;
  localparam int MAX_BITS_DEF    = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_SHORT  = 2'd1,
    STAT_OVFL   = 2'd2,
    STAT_BADCNT = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] bits_done;
    stat_t            status;
  } res_t;

endpackage

// ===== rtl/bfp_store.sv =====
// ----------------------------------------------------------------------------
// bfp_store - byte store of the bit FIFO
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfp_store #(
  parameter int STORE_BYTES = bfp_pkg::STORE_BYTES_DEF,
  localparam int ADDR_W     = $clog2(STORE_BYTES)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [bfp_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [bfp_pkg::BYTE_W-1:0] rdata
);

  logic [bfp_pkg::BYTE_W-1:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bfp_seq.sv =====
// ----------------------------------------------------------------------------
// bfp_seq - item sequencer of the bit FIFO packer
// Decodes an item, then walks the touched bytes: read-modify-write for writes, read only for reads.
// ----------------------------------------------------------------------------
module bfp_seq #(
  parameter int STORE_BYTES = bfp_pkg::STORE_BYTES_DEF,
  parameter int MAX_BITS    = bfp_pkg::MAX_BITS_DEF,
  localparam int CAP_BITS   = STORE_BYTES * bfp_pkg::BYTE_W,
  localparam int PTR_W      = $clog2(CAP_BITS),
  localparam int FILL_W     = $clog2(CAP_BITS + 1),
  localparam int ADDR_W     = $clog2(STORE_BYTES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // item input
  input  logic                       in_valid,
  input  logic                       in_operation,
  input  logic [bfp_pkg::VAL_W-1:0]  in_value,
  input  logic [bfp_pkg::CNT_W-1:0]  in_count,
  output logic                       busy,
  // result hand-off
  output logic                       res_valid,
  input  logic                       res_take,
  output bfp_pkg::res_t              res,
  // store port
  output logic                       mem_we,
  output logic                       mem_re,
  output logic [ADDR_W-1:0]          mem_addr,
  output logic [bfp_pkg::BYTE_W-1:0] mem_wdata,
  input  logic [bfp_pkg::BYTE_W-1:0] mem_rdata
);

  localparam int ACC_W = MAX_BITS;
  localparam int CW    = bfp_pkg::CNT_W;

  bfp_pkg::seq_state_t state_r, state_nxt;

  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0]  p_r, p_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  bfp_pkg::op_t      op_r, op_nxt;
  bfp_pkg::stat_t    stat_r, stat_nxt;

  // decode
  logic              cnt_ok;
  logic [FILL_W:0]   fill_sum;
  logic              ovfl;
  logic [CW-1:0]     n_rd;
  logic [ACC_W+bfp_pkg::VAL_W-1:0] val_wide;
  logic [6:0]        align_sh;

  // byte step
  logic [2:0]        off;
  logic [3:0]        room;
  logic [3:0]        k;
  logic [3:0]        off_k;
  logic [7:0]        mask;
  logic [7:0]        top8;
  logic [7:0]        wbyte;
  logic [7:0]        gbyte;
  logic [PTR_W:0]    p_sum;
  logic [PTR_W-1:0]  p_adv;

  // result
  logic [CW-1:0]     fin_sh;
  logic [ACC_W+bfp_pkg::VAL_W-1:0] fin_wide;

  always_comb begin
    cnt_ok   = (in_count != '0) && ({1'b0, in_count} <= 7'(MAX_BITS));
    fill_sum = {1'b0, fill_r} + (FILL_W+1)'(in_count);
    ovfl     = fill_sum > (FILL_W+1)'(CAP_BITS);
    n_rd     = (FILL_W'(in_count) > fill_r) ? CW'(fill_r) : in_count;
    val_wide = {{ACC_W{1'b0}}, in_value};
    align_sh = 7'(MAX_BITS) - {1'b0, in_count};

    off   = p_r[2:0];
    room  = 4'd8 - {1'b0, off};
    k     = ({2'b00, room} > rem_r) ? rem_r[3:0] : room;
    off_k = {1'b0, off} + k;
    mask  = (8'hFF >> off) & ~(8'hFF >> off_k);
    top8  = acc_r[ACC_W-1 -: 8];
    wbyte = (mem_rdata & ~mask) | ((top8 >> off) & mask);
    gbyte = mem_rdata << off;
    p_sum = {1'b0, p_r} + (PTR_W+1)'(k);
    p_adv = (p_sum == (PTR_W+1)'(CAP_BITS)) ? '0 : p_sum[PTR_W-1:0];

    fin_sh   = cnt_r - done_r;
    fin_wide = {{bfp_pkg::VAL_W{1'b0}}, acc_r} << fin_sh;
  end

  // datapath next values
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    p_nxt    = p_r;
    rem_nxt  = rem_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    op_nxt   = op_r;
    stat_nxt = stat_r;
    case (state_r)
      bfp_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt  = bfp_pkg::op_t'(in_operation);
          cnt_nxt = in_count;
          acc_nxt = '0;
          rem_nxt = '0;
          done_nxt = '0;
          if (!cnt_ok) begin
            stat_nxt = bfp_pkg::STAT_BADCNT;
          end else if (bfp_pkg::op_t'(in_operation) == bfp_pkg::OP_WRITE) begin
            if (ovfl) begin
              stat_nxt = bfp_pkg::STAT_OVFL;
            end else begin
              stat_nxt = bfp_pkg::STAT_OK;
              rem_nxt  = in_count;
              done_nxt = in_count;
              p_nxt    = wptr_r;
              fill_nxt = fill_sum[FILL_W-1:0];
              acc_nxt  = ACC_W'(val_wide << align_sh);
            end
          end else begin
            stat_nxt = (n_rd < in_count) ? bfp_pkg::STAT_SHORT : bfp_pkg::STAT_OK;
            rem_nxt  = n_rd;
            done_nxt = n_rd;
            p_nxt    = rptr_r;
            fill_nxt = fill_r - FILL_W'(n_rd);
          end
        end
      end
      bfp_pkg::S_MOD: begin
        p_nxt   = p_adv;
        rem_nxt = rem_r - CW'(k);
        if (op_r == bfp_pkg::OP_WRITE) begin
          acc_nxt  = acc_r << k;
          wptr_nxt = p_adv;
        end else begin
          acc_nxt  = (acc_r << k) | ACC_W'(gbyte >> (4'd8 - k));
          rptr_nxt = p_adv;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfp_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (rem_nxt != '0) ? bfp_pkg::S_RD : bfp_pkg::S_DONE;
        end
      end
      bfp_pkg::S_RD:   state_nxt = bfp_pkg::S_MOD;
      bfp_pkg::S_MOD:  state_nxt = (rem_nxt == '0) ? bfp_pkg::S_DONE : bfp_pkg::S_RD;
      bfp_pkg::S_DONE: begin
        if (res_take) begin
          state_nxt = bfp_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfp_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != bfp_pkg::S_IDLE);
    mem_re    = (state_r == bfp_pkg::S_RD);
    mem_we    = (state_r == bfp_pkg::S_MOD) && (op_r == bfp_pkg::OP_WRITE);
    mem_addr  = p_r[PTR_W-1:3];
    mem_wdata = wbyte;
    res_valid = (state_r == bfp_pkg::S_DONE);
    res.read_value = (op_r == bfp_pkg::OP_READ) ? fin_wide[bfp_pkg::VAL_W-1:0] : '0;
    res.bits_done  = done_r;
    res.status     = stat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfp_pkg::S_IDLE;
      wptr_r  <= '0;
      rptr_r  <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    rem_r  <= rem_nxt;
    done_r <= done_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    op_r   <= op_nxt;
    stat_r <= stat_nxt;
  end

endmodule

// ===== rtl/bit_fifo_packer_unit.sv =====
// ----------------------------------------------------------------------------
// bit_fifo_packer_unit - MSB-first bit FIFO over a byte store
// Writes append 1..MAX_BITS bits, reads remove up to MAX_BITS bits.
// ----------------------------------------------------------------------------
// A write transfer appends the low in_count bits of in_value, most significant
// first; a read transfer removes up to in_count bits and returns them
// MSB-aligned in a count-wide field of out_read_value. Each input transfer
// yields exactly one result transfer with a status: ok, short read (queue ran
// dry, out_bits_done tells how many bits came out), write overflow (write
// rejected whole, nothing stored) or bad count (0 or above MAX_BITS, nothing
// changes). Capacity is STORE_BYTES*8 bits. The block handles one item at a
// time: in an item that touches B bytes of the store (B is 1 to 5 for 32-bit
// counts), every byte goes through a read state and a modify/write state (the
// write only for write items), with one address driven to both ports of the
// byte store; the result then waits in the done state until the output
// register takes it. Rejected items and reads of an empty queue skip the byte
// walk. A new item may be accepted while the previous result still waits in
// the output register; a second finished result waits in the sequencer and
// stalls the input until the output register drains.
// ----------------------------------------------------------------------------
module bit_fifo_packer_unit #(
  parameter int STORE_BYTES = bfp_pkg::STORE_BYTES_DEF,
  parameter int MAX_BITS    = bfp_pkg::MAX_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic [bfp_pkg::VAL_W-1:0] in_value,
  input  logic [bfp_pkg::CNT_W-1:0] in_count,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bfp_pkg::VAL_W-1:0] out_read_value,
  output logic [bfp_pkg::CNT_W-1:0] out_bits_done,
  output logic [1:0]                out_status
);

  localparam int ADDR_W = $clog2(STORE_BYTES);

  logic                       busy;
  logic                       res_valid;
  logic                       res_take;
  bfp_pkg::res_t              res;
  logic                       mem_we;
  logic                       mem_re;
  logic [ADDR_W-1:0]          mem_addr;
  logic [bfp_pkg::BYTE_W-1:0] mem_wdata;
  logic [bfp_pkg::BYTE_W-1:0] mem_rdata;

  logic          out_valid_r, out_valid_nxt;
  bfp_pkg::res_t out_res_r;

  // Sequencer: decode, byte-wise reads and read-modify-writes, pointer/fill bookkeeping.
  bfp_seq #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_BITS    (MAX_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_count     (in_count),
    .busy         (busy),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res),
    .mem_we       (mem_we),
    .mem_re       (mem_re),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata)
  );

  // Byte store; no clearing needed, reads only use bits already written.
  bfp_store #(
    .STORE_BYTES (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // Input is taken only when the sequencer sits idle.
  assign in_stall = busy;

  // Output register: free when empty or being drained this cycle.
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_res_r.read_value;
  assign out_bits_done  = out_res_r.bits_done;
  assign out_status     = out_res_r.status;

  // Never more bits than a single item can carry.
  a_done_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_res_r.bits_done} <= 7'(MAX_BITS)))
    else $error("bits_done above MAX_BITS");

  // Rejected items move no bits and return no data.
  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status == bfp_pkg::STAT_OVFL ||
                    out_res_r.status == bfp_pkg::STAT_BADCNT)
    |-> (out_res_r.bits_done == '0) && (out_res_r.read_value == '0))
    else $error("rejected item reports data");

  // A successful item always moves at least one bit.
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status == bfp_pkg::STAT_OK)
    |-> (out_res_r.bits_done != '0))
    else $error("ok status with zero bits");

  // A result is loaded only from a finished sequencer.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_valid) && $past(busy))
    else $error("output loaded without a finished item");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - bit_fifo_packer_unit self-checking bench
// Drives write and read transfers with random idling on both sides. A bit
// queue tracks the expected FIFO contents, and every result is checked.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CAP_BITS     = bfp_pkg::STORE_BYTES_DEF * bfp_pkg::BYTE_W;
  localparam int IDLE_PCT     = 38;
  localparam int SETTLE_TICKS = 16;    // covers the longest item, plus margin
  localparam int STUCK_LIMIT  = 4000;  // cycles with no transfer on either side
  localparam int REPORT_MAX   = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps the queued bits in arrival order and, for every accepted
  // input, works out the result the block owes. Results are matched in order.
  // --------------------------------------------------------------------------
  class packer_scoreboard;
    bit            queued_bits[$];
    bfp_pkg::res_t owed_results[$];
    int            mismatches;
    int            checked;
    int            n_write, n_read, n_short, n_ovfl, n_badcnt;

    function void note_transfer(bfp_pkg::op_t op, logic [bfp_pkg::VAL_W-1:0] value,
                                logic [bfp_pkg::CNT_W-1:0] count);
      bfp_pkg::res_t r;
      r = '0;
      r.status = bfp_pkg::STAT_OK;
      if (count == 0 || count > bfp_pkg::MAX_BITS_DEF) begin
        r.status = bfp_pkg::STAT_BADCNT;
        n_badcnt++;
      end else if (op == bfp_pkg::OP_WRITE) begin
        n_write++;
        if (queued_bits.size() + count > CAP_BITS) begin
          r.status = bfp_pkg::STAT_OVFL;  // rejected whole, queue untouched
          n_ovfl++;
        end else begin
          for (int i = count - 1; i >= 0; i--)
            queued_bits.push_back(value[i]);
          r.bits_done = count;
        end
      end else begin
        n_read++;
        // oldest bit lands at bit count-1, the rest follow downwards
        for (int i = count - 1; i >= 0 && queued_bits.size() > 0; i--) begin
          r.read_value[i] = queued_bits.pop_front();
          r.bits_done = r.bits_done + 1'b1;
        end
        if (r.bits_done < count) begin
          r.status = bfp_pkg::STAT_SHORT;
          n_short++;
        end
      end
      owed_results.push_back(r);
    endfunction

    function void check_transfer(logic [bfp_pkg::VAL_W-1:0] rv,
                                 logic [bfp_pkg::CNT_W-1:0] bd, logic [1:0] st);
      bfp_pkg::res_t e;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: result with nothing owed: value %h done %0d status %0d",
                   rv, bd, st);
        return;
      end
      e = owed_results.pop_front();
      checked++;
      if (rv !== e.read_value || bd !== e.bits_done || st !== e.status) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"ERROR: result %0d: expected value %h done %0d status %0d,",
                    " got value %h done %0d status %0d"}, checked,
                   e.read_value, e.bits_done, e.status, rv, bd, st);
      end
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; everything known from time zero
  // --------------------------------------------------------------------------
  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      in_valid     = 1'b0;
  logic                      in_operation = 1'b0;
  logic [bfp_pkg::VAL_W-1:0] in_value     = '0;
  logic [bfp_pkg::CNT_W-1:0] in_count     = '0;
  logic                      out_stall    = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic [bfp_pkg::VAL_W-1:0] out_read_value;
  logic [bfp_pkg::CNT_W-1:0] out_bits_done;
  logic [1:0]                out_status;

  bit               calm = 1'b0;  // no idling on either side while set
  int               stuck = 0;
  packer_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bit_fifo_packer_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_count       (in_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_bits_done  (out_bits_done),
    .out_status     (out_status)
  );

  // --------------------------------------------------------------------------
  // Monitors. Sampling at the rising edge sees the values from before the
  // edge, so a transfer is exactly valid high and stall low at that edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_transfer(bfp_pkg::op_t'(in_operation), in_value, in_count);
  end

  // Result side: take what is offered, then pick the next stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_transfer(out_read_value, out_bits_done, out_status);
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: any transfer on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck <= 0;
    else
      stuck <= stuck + 1;
  end

  initial begin
    while (stuck < STUCK_LIMIT) @(posedge clk);
    $display("ERROR: no transfer for %0d cycles, %0d results still owed",
             STUCK_LIMIT, sb.owed());
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // Offer one item after a random gap; returns at the edge that takes it.
  task automatic send_item(bfp_pkg::op_t op, logic [bfp_pkg::VAL_W-1:0] value,
                           logic [bfp_pkg::CNT_W-1:0] count);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= value;
    in_count     <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off until the block owes nothing, then let it settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Random items; wide biases toward full 32-bit counts to push the queue full.
  task automatic send_random(int n, int write_pct, bit wide);
    int                        r;
    bfp_pkg::op_t              op;
    logic [bfp_pkg::CNT_W-1:0] cnt;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 5)
        cnt = $urandom_range(1) ? 6'd0 : 6'($urandom_range(33, 63));
      else if (wide)
        cnt = 6'd32;
      else if (r < 15)
        cnt = $urandom_range(1) ? 6'd32 : 6'd1;
      else
        cnt = 6'($urandom_range(1, 32));
      op = ($urandom_range(99) < write_pct) ? bfp_pkg::OP_WRITE : bfp_pkg::OP_READ;
      send_item(op, $urandom, cnt);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, bad counts, field extremes, ignored value bits
    send_item(bfp_pkg::OP_READ,  32'hFFFF_FFFF, 6'd1);   // empty queue, no bits
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd32);
    send_item(bfp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd0);   // bad count, zero
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd33);  // bad count, just above max
    send_item(bfp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd63);  // bad count, all ones
    send_item(bfp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd32);
    send_item(bfp_pkg::OP_WRITE, 32'h0,         6'd1);
    send_item(bfp_pkg::OP_WRITE, 32'hFFFF_FFE5, 6'd5);   // upper bits must be dropped
    send_item(bfp_pkg::OP_WRITE, 32'h0,         6'd32);
    send_item(bfp_pkg::OP_WRITE, 32'hA5C3_0F96, 6'd32);
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd32);
    send_item(bfp_pkg::OP_READ,  32'hFFFF_FFFF, 6'd1);
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd7);
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd32);
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd32);  // runs dry partway
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd32);  // empty again
    send_item(bfp_pkg::OP_WRITE, 32'h5,         6'd3);
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd8);   // short, bits at the top
    send_item(bfp_pkg::OP_WRITE, 32'h0000_0ABC, 6'd12);  // order kept after a drain
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd4);
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd8);
    send_item(bfp_pkg::OP_WRITE, 32'h1,         6'd1);
    send_item(bfp_pkg::OP_READ,  32'h0,         6'd1);
    wait_drained();

    // Random: mixed traffic, fill past capacity, hover near full, drain,
    // then a stretch with both sides running flat out.
    send_random(300, 50, 1'b0);
    wait_drained();
    send_random(200, 95, 1'b1);
    send_random(80, 60, 1'b0);
    send_random(220, 10, 1'b0);
    calm = 1'b1;
    send_random(150, 50, 1'b0);
    calm = 1'b0;
    send_random(150, 50, 1'b0);

    wait_drained();

    $display("Run covered %0d results: %0d writes, %0d reads, %0d bad counts",
             sb.checked, sb.n_write, sb.n_read, sb.n_badcnt);
    $display("  of which %0d short reads and %0d rejected writes; %0d mismatches",
             sb.n_short, sb.n_ovfl, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
